@@ hdl/multi_lane_fnv_hash_unit_defines.svh @@
// Assertion helpers used by the hash unit output module.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef MULTI_LANE_FNV_HASH_UNIT_DEFINES_SVH
`define MULTI_LANE_FNV_HASH_UNIT_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define MLFNV_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that implies a consequence on the next clock.
`define MLFNV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/mlfnv_pkg.sv @@
`default_nettype none
package mlfnv_pkg;

  localparam int DEF_LANES  = 4;
  localparam int IN_LANES   = 4;
  localparam int OUT_FIELDS = 4;

  localparam logic [31:0] BASIS32 = 32'h811c_9dc5;
  localparam logic [63:0] BASIS64 = 64'hcbf2_9ce4_8422_2325;

  localparam int          ADDR_W         = 3;
  localparam logic [2:0]  ADDR_XOR_FIRST = 3'd0;
  localparam logic [2:0]  ADDR_WIDE_HASH = 3'd4;

  typedef struct packed {
    logic [31:0] lane_bytes;
    logic [3:0]  lane_valid;
    logic        first;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [63:0] digest_lane0;
    logic [63:0] digest_lane1;
    logic [63:0] digest_lane2;
    logic [63:0] digest_lane3;
  } out_t;

  typedef struct packed {
    logic accept;
    logic first;
    logic xor_first;
    logic wide_hash;
  } lane_ctrl_t;

  // Multiply by 0x00000100000001B3 as shifted adds.
  function automatic logic [63:0] mul_prime64(input logic [63:0] x);
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  // Multiply by 0x01000193 as shifted adds.
  function automatic logic [31:0] mul_prime32(input logic [31:0] x);
    return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

endpackage
`default_nettype wire

@@ hdl/mlfnv_lane.sv @@
`default_nettype none
module mlfnv_lane (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire mlfnv_pkg::lane_ctrl_t ctrl,
  input  wire  [7:0]              lane_byte,
  input  wire                     byte_valid,
  output logic [63:0]             hash_nxt
);
  import mlfnv_pkg::*;

  logic [63:0] hash_r;
  logic [63:0] basis;
  logic [63:0] base;
  logic [63:0] wide_res;
  logic [31:0] narrow_res;
  logic [63:0] absorbed;

  assign basis = ctrl.wide_hash ? BASIS64 : {32'b0, BASIS32};
  assign base  = ctrl.first ? basis : hash_r;

  always_comb begin
    if (ctrl.xor_first) begin
      wide_res   = mul_prime64(base ^ {56'b0, lane_byte});
      narrow_res = mul_prime32(base[31:0] ^ {24'b0, lane_byte});
    end else begin
      wide_res   = mul_prime64(base) ^ {56'b0, lane_byte};
      narrow_res = mul_prime32(base[31:0]) ^ {24'b0, lane_byte};
    end
  end

  assign absorbed = ctrl.wide_hash ? wide_res : {32'b0, narrow_res};

  always_comb begin
    hash_nxt = hash_r;
    if (ctrl.accept) begin
      if (byte_valid) begin
        hash_nxt = absorbed;
      end else begin
        hash_nxt = base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= {32'b0, BASIS32};
    end else begin
      hash_r <= hash_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/mlfnv_out.sv @@
`default_nettype none
`include "multi_lane_fnv_hash_unit_defines.svh"
module mlfnv_out #(
  parameter int LANES = mlfnv_pkg::DEF_LANES
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          push,
  input  wire  [LANES-1:0][63:0]       lane_hash,
  input  wire                          wide_hash,
  input  wire                          out_stall,
  output logic                         out_valid,
  output mlfnv_pkg::out_t              out_data,
  output logic                         full
);
  import mlfnv_pkg::*;

  logic [OUT_FIELDS-1:0][63:0] dig;
  out_t merged;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  out_t out_data_r, out_data_nxt;
  out_t skid_data_r, skid_data_nxt;
  logic out_take;

  for (genvar i = 0; i < OUT_FIELDS; i++) begin : g_dig
    if (i < LANES) begin : g_live
      assign dig[i] = wide_hash ? lane_hash[i] : {32'b0, lane_hash[i][31:0]};
    end else begin : g_absent
      assign dig[i] = 64'b0;
    end
  end

  assign merged = '{digest_lane0: dig[0], digest_lane1: dig[1],
                    digest_lane2: dig[2], digest_lane3: dig[3]};

  assign out_take = out_valid_r & ~out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || out_take) begin
        out_data_nxt  = merged;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = merged;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign full      = skid_valid_r;

  `MLFNV_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_r || out_valid_r, "skid holds a transaction while output is empty")
  `MLFNV_ASSERT_ALWAYS(a_no_push_when_full, !(push && skid_valid_r), "digest pushed while skid is full")
  `MLFNV_ASSERT_NEXT(a_skid_drains, skid_valid_r && !out_stall, !skid_valid_r && out_valid_r, "skid did not drain")

endmodule
`default_nettype wire

@@ hdl/multi_lane_fnv_hash_unit.sv @@
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall    in_data (mlfnv_pkg::in_t)
// out_      output     out_valid / out_stall  out_data (mlfnv_pkg::out_t)
// APB       input      psel / penable         paddr, pwdata, prdata
//
// One input transaction is taken every cycle while in_stall is low; each lane absorbs its byte in that cycle.
// The lane multiply by the prime is a short chain of shifted adds and sets the clock period.
// A transaction with last is registered into the output slot, or into the skid slot while out_stall holds the output.
// Reset is synchronous and loads every lane with the 32-bit offset basis.
// Two output slots let the input run on while one digest set waits; in_stall rises
// only when both are full.
`default_nettype none
module multi_lane_fnv_hash_unit #(
  parameter int LANES = mlfnv_pkg::DEF_LANES
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire mlfnv_pkg::in_t              in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output mlfnv_pkg::out_t                  out_data,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [mlfnv_pkg::ADDR_W-1:0]     paddr,
  input  wire  [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import mlfnv_pkg::*;

  logic xor_first_r, xor_first_nxt;
  logic wide_hash_r, wide_hash_nxt;
  logic cfg_wr;
  lane_ctrl_t ctrl;
  logic [LANES-1:0][63:0] lane_hash;
  logic full;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    xor_first_nxt = xor_first_r;
    wide_hash_nxt = wide_hash_r;
    if (cfg_wr) begin
      unique case (paddr)
        ADDR_XOR_FIRST: xor_first_nxt = pwdata[0];
        ADDR_WIDE_HASH: wide_hash_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_XOR_FIRST: prdata = {31'b0, xor_first_r};
      ADDR_WIDE_HASH: prdata = {31'b0, wide_hash_r};
      default:        prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_first_r <= 1'b1;
      wide_hash_r <= 1'b0;
    end else begin
      xor_first_r <= xor_first_nxt;
      wide_hash_r <= wide_hash_nxt;
    end
  end

  assign in_stall = full;

  assign ctrl = '{accept: in_valid & ~full, first: in_data.first,
                  xor_first: xor_first_r, wide_hash: wide_hash_r};

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    if (g < IN_LANES) begin : g_fed
      mlfnv_lane u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .lane_byte  (in_data.lane_bytes[8*g +: 8]),
        .byte_valid (in_data.lane_valid[g]),
        .hash_nxt   (lane_hash[g])
      );
    end else begin : g_idle
      mlfnv_lane u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .lane_byte  (8'b0),
        .byte_valid (1'b0),
        .hash_nxt   (lane_hash[g])
      );
    end
  end

  mlfnv_out #(
    .LANES (LANES)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ctrl.accept & in_data.last),
    .lane_hash (lane_hash),
    .wide_hash (wide_hash_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (full)
  );

endmodule
`default_nettype wire

@@ verif/tb_multi_lane_fnv_hash_unit.sv @@
`timescale 1ns / 1ps
module tb_multi_lane_fnv_hash_unit;
  import mlfnv_pkg::*;

  localparam logic [31:0] FNV_PRIME32 = 32'h0100_0193;
  localparam logic [63:0] FNV_PRIME64 = 64'h0000_0100_0000_01b3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 80;
  localparam int DRAIN_CYCLES = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  in_t pending_items[$];
  out_t expected_digests[$];
  logic [63:0] lane_hash [4];
  bit mode_xor_first = 1'b1;
  bit mode_wide = 1'b0;
  bit no_idle = 1'b0;
  bit long_hold_req = 1'b0;
  int errors = 0;
  int items_taken = 0;
  int digests_seen = 0;
  int messages_queued = 0;
  int watchdog_count = 0;
  int drv_gap = 0;
  int stall_left = 0;

  multi_lane_fnv_hash_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_t mk_item(logic [31:0] b, logic [3:0] v, logic f, logic l);
    in_t t;
    t.lane_bytes = b;
    t.lane_valid = v;
    t.first = f;
    t.last = l;
    return t;
  endfunction

  function automatic logic [63:0] offset_basis();
    return mode_wide ? BASIS64 : {32'd0, BASIS32};
  endfunction

  function automatic logic [63:0] fnv_absorb(logic [63:0] h, logic [7:0] b);
    logic [31:0] s;
    if (mode_wide) begin
      if (mode_xor_first) return (h ^ {56'd0, b}) * FNV_PRIME64;
      return (h * FNV_PRIME64) ^ {56'd0, b};
    end
    s = h[31:0];
    if (mode_xor_first) s = (s ^ {24'd0, b}) * FNV_PRIME32;
    else s = (s * FNV_PRIME32) ^ {24'd0, b};
    return {32'd0, s};
  endfunction

  function automatic logic [63:0] lane_digest(int i);
    return mode_wide ? lane_hash[i] : {32'd0, lane_hash[i][31:0]};
  endfunction

  task automatic absorb_transaction(in_t t);
    out_t d;
    int i;
    for (i = 0; i < 4; i++) begin
      if (t.first) lane_hash[i] = offset_basis();
      if (t.lane_valid[i]) lane_hash[i] = fnv_absorb(lane_hash[i], t.lane_bytes[8*i +: 8]);
    end
    if (t.last) begin
      d.digest_lane0 = lane_digest(0);
      d.digest_lane1 = lane_digest(1);
      d.digest_lane2 = lane_digest(2);
      d.digest_lane3 = lane_digest(3);
      expected_digests.push_back(d);
    end
  endtask

  task automatic queue_traffic(int n);
    int added;
    int len;
    int k;
    logic [3:0] v;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 9) < 8) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
        for (k = 0; k < len; k++) begin
          v = ($urandom_range(0, 1) == 0) ? 4'hf : 4'($urandom_range(0, 15));
          pending_items.push_back(mk_item($urandom, v, k == 0, k == len - 1));
        end
        added += len;
        messages_queued++;
      end else begin
        pending_items.push_back(mk_item($urandom, 4'($urandom), 1'($urandom), 1'($urandom)));
        added++;
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_digests.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [ADDR_W-1:0] addr, bit value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_XOR_FIRST) mode_xor_first = value;
    else if (addr == ADDR_WIDE_HASH) mode_wide = value;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : item_driver
    bit slot_free;
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap = 0;
    end else begin
      slot_free = !in_valid || !in_stall;
      if (in_valid && !in_stall) begin
        absorb_transaction(in_data);
        items_taken++;
        drv_gap = pick_gap();
      end
      if (slot_free) begin
        if (drv_gap == 0 && pending_items.size() != 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (drv_gap > 0) drv_gap--;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : digest_check
    out_t want;
    logic [63:0] w [4];
    logic [63:0] g [4];
    int i;
    if (rst_n && out_valid && !out_stall) begin
      digests_seen++;
      if (expected_digests.size() == 0) begin
        errors++;
        $display("%0t: digest transaction with none expected, got %h", $time, out_data);
      end else begin
        want = expected_digests.pop_front();
        w = '{want.digest_lane0, want.digest_lane1, want.digest_lane2, want.digest_lane3};
        g = '{out_data.digest_lane0, out_data.digest_lane1,
              out_data.digest_lane2, out_data.digest_lane3};
        for (i = 0; i < 4; i++) begin
          if (g[i] !== w[i]) begin
            errors++;
            $display("%0t: lane %0d digest expected %h, got %h", $time, i, w[i], g[i]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) watchdog_count = 0;
      else watchdog_count++;
      if (watchdog_count >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int p;
    int k;
    for (k = 0; k < 4; k++) lane_hash[k] = {32'd0, BASIS32};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, starting from the reset configuration.
    no_idle = 1'b1;
    pending_items.push_back(mk_item($urandom, 4'hf, 1'b0, 1'b1));
    pending_items.push_back(mk_item(32'h0000_0000, 4'hf, 1'b1, 1'b1));
    pending_items.push_back(mk_item(32'hffff_ffff, 4'hf, 1'b1, 1'b1));
    pending_items.push_back(mk_item($urandom, 4'h0, 1'b1, 1'b1));
    pending_items.push_back(mk_item($urandom, 4'h1, 1'b1, 1'b0));
    pending_items.push_back(mk_item($urandom, 4'h3, 1'b0, 1'b0));
    pending_items.push_back(mk_item($urandom, 4'hf, 1'b0, 1'b0));
    pending_items.push_back(mk_item($urandom, 4'h8, 1'b0, 1'b1));
    pending_items.push_back(mk_item($urandom, 4'hf, 1'b1, 1'b0));
    pending_items.push_back(mk_item($urandom, 4'h5, 1'b0, 1'b0));
    wait_idle();
    write_reg(ADDR_XOR_FIRST, 1'b0);
    pending_items.push_back(mk_item($urandom, 4'hf, 1'b0, 1'b1));
    wait_idle();
    write_reg(ADDR_WIDE_HASH, 1'b1);
    pending_items.push_back(mk_item(32'h0000_0000, 4'hf, 1'b1, 1'b1));
    pending_items.push_back(mk_item(32'hffff_ffff, 4'hf, 1'b1, 1'b1));
    pending_items.push_back(mk_item($urandom, 4'h0, 1'b1, 1'b1));
    pending_items.push_back(mk_item($urandom, 4'ha, 1'b1, 1'b0));
    wait_idle();
    write_reg(ADDR_XOR_FIRST, 1'b1);
    pending_items.push_back(mk_item($urandom, 4'hf, 1'b0, 1'b1));
    pending_items.push_back(mk_item($urandom, 4'hf, 1'b1, 1'b0));
    wait_idle();
    write_reg(ADDR_WIDE_HASH, 1'b0);
    pending_items.push_back(mk_item($urandom, 4'hf, 1'b0, 1'b1));

    // Random phases over all four modes, then random modes.
    for (p = 0; p < 6; p++) begin
      wait_idle();
      write_reg(ADDR_XOR_FIRST, (p < 4) ? p[0] : 1'($urandom_range(0, 1)));
      write_reg(ADDR_WIDE_HASH, (p < 4) ? p[1] : 1'($urandom_range(0, 1)));
      if (p == 3) begin
        // Hold the output off long enough for the block to fill and stall its input.
        no_idle = 1'b1;
        long_hold_req = 1'b1;
        for (k = 0; k < 30; k++)
          pending_items.push_back(mk_item($urandom, 4'($urandom), 1'b1, 1'b1));
        wait_idle();
      end
      no_idle = (p == 2);
      queue_traffic(120);
    end

    wait_idle();
    repeat (8) @(negedge clk);
    $display("Checked %0d input transactions and %0d digest transactions (%0d random messages)",
             items_taken, digests_seen, messages_queued);
    $display("in FNV-1 and FNV-1a at 32 and 64 bits, with mode changes mid-message and back-pressure.");
    if (errors == 0 && expected_digests.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
